FILE: hdl/hall_angle_cyclic_pulse_mixer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hall angle cyclic pulse mixer
// Shared helpers so that every checker reports in the same way.
// ----------------------------------------------------------------------------
`ifndef HALL_ANGLE_CYCLIC_PULSE_MIXER_DEFINES_SVH
`define HALL_ANGLE_CYCLIC_PULSE_MIXER_DEFINES_SVH

// property checked at every edge, reset included
`define HACPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked outside reset only
`define HACPM_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: hdl/hacpm_pkg.sv
// ----------------------------------------------------------------------------
// hacpm_pkg
// Constants, types and trig tables of the hall angle cyclic pulse mixer.
// ----------------------------------------------------------------------------
package hacpm_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int CMD_BITS_DEF    = 11;
   localparam int MID_W           = 12;
   localparam int BASE_W          = 16;
   localparam int PHASE_W         = 9;
   localparam int ANGLE_W         = 9;
   localparam int DEG_W           = 7;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int RSP_DATA_W      = 32;
   localparam int SEARCH_STEPS    = 7;

   localparam logic [BASE_W-1:0]  PULSE_BASE_RST = 16'd1000;
   localparam logic [MID_W-1:0]   HALL_MID_RST   = 12'd1250;
   localparam logic [PHASE_W-1:0] PHASE_RST      = 9'd45;
   localparam int                 PULSE_OFFSET   = 500;
   localparam int                 HALF_UNIT      = 327680;
   localparam logic [DEG_W-1:0]   DEG_LAST       = 7'd89;

   localparam logic [ANGLE_W-1:0] DEG_0   = 9'd0;
   localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
   localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
   localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
   localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_PULSE_BASE    = 2'd0,
      REG_HALL_MIDPOINT = 2'd1,
      REG_PHASE_OFFSET  = 2'd2
   } csr_index_type;

   // angle decode flags carried alongside the arctangent search
   typedef struct packed {
      logic                special;
      logic [ANGLE_W-1:0]  special_angle;
      logic                a_neg;
      logic                b_neg;
      logic                eq;
   } hacpm_flags_type;

   typedef logic [30:0] sin30_tab_type [0:90];
   typedef logic [14:0] sin15_tab_type [0:90];

   // Taylor term n divided by (2n)(2n+1)
   function automatic longint unsigned taylor_div(input longint unsigned t, input int n);
      case (n)
         1:       return t / 6;
         2:       return t / 20;
         3:       return t / 42;
         4:       return t / 72;
         5:       return t / 110;
         6:       return t / 156;
         7:       return t / 210;
         8:       return t / 272;
         9:       return t / 342;
         default: return t / 420;
      endcase
   endfunction

   // sine in Q1.30 by a truncated Taylor series, worked out at elaboration
   function automatic sin30_tab_type build_sin30();
      sin30_tab_type     tab;
      longint unsigned   x;
      longint unsigned   t;
      longint            sum;
      for (int k = 0; k <= 90; k++) begin
         x   = longint'(k) * 64'd18740330;
         t   = x;
         sum = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            t   = (t * x) >> 30;
            t   = (t * x) >> 30;
            t   = taylor_div(t, n);
            if (n % 2 == 1) sum = sum - longint'(t);
            else            sum = sum + longint'(t);
         end
         if (sum < 0) sum = 0;
         tab[k] = sum[30:0];
      end
      return tab;
   endfunction

   localparam sin30_tab_type SIN30_TAB = build_sin30();

   // Q1.15 rounding of the Q30 table, unit sine capped at 32767
   function automatic sin15_tab_type build_sin15();
      sin15_tab_type tab;
      longint        q;
      for (int k = 0; k <= 90; k++) begin
         q = (longint'(SIN30_TAB[k]) + 16384) >>> 15;
         tab[k] = (q > 32767) ? 15'd32767 : q[14:0];
      end
      return tab;
   endfunction

   localparam sin15_tab_type SIN15_TAB = build_sin15();

   // sine of a whole-degree angle 0..359 by quadrant symmetry
   function automatic logic signed [15:0] sin_deg(input logic [ANGLE_W-1:0] d);
      logic [ANGLE_W-1:0] r;
      logic               neg;
      logic [14:0]        mag;
      if (d < DEG_90) begin
         r = d; neg = 1'b0;
      end else if (d < DEG_180) begin
         r = DEG_180 - d; neg = 1'b0;
      end else if (d < DEG_270) begin
         r = d - DEG_180; neg = 1'b1;
      end else begin
         r = DEG_360 - d; neg = 1'b1;
      end
      mag = SIN15_TAB[r[DEG_W-1:0]];
      return neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
   endfunction

endpackage

FILE: hdl/hacpm_atan_stage.sv
// ----------------------------------------------------------------------------
// hacpm_atan_stage
// One step of the binary search for the first-quadrant angle floor.
// ----------------------------------------------------------------------------
module hacpm_atan_stage
   import hacpm_pkg::*;
#(
   parameter int MAG_W    = 12,
   parameter int SIDE_W   = 46,
   parameter int STEP_BIT = 6
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [MAG_W-1:0]  src_am,
   input  logic [MAG_W-1:0]  src_bm,
   input  logic [DEG_W-1:0]  src_deg,
   input  logic [SIDE_W-1:0] src_side,
   output logic [MAG_W-1:0]  am,
   output logic [MAG_W-1:0]  bm,
   output logic [DEG_W-1:0]  deg,
   output logic [SIDE_W-1:0] side
);

   localparam int PW = MAG_W + 31;

   logic [DEG_W-1:0]  cand;
   logic              in_range;
   logic [DEG_W-1:0]  idx;
   logic [PW-1:0]     prod_b;
   logic [PW-1:0]     prod_a;
   logic [MAG_W-1:0]  am_ff, bm_ff;
   logic [DEG_W-1:0]  deg_ff, deg_in;
   logic [SIDE_W-1:0] side_ff;

   // test b*sin(90-k) >= a*sin(k) for the candidate k
   always_comb begin
      cand     = src_deg | DEG_W'(1 << STEP_BIT);
      in_range = (cand <= DEG_LAST);
      idx      = in_range ? cand : 7'd1;
      prod_b   = PW'(src_bm) * PW'(SIN30_TAB[DEG_W'(7'd90 - idx)]);
      prod_a   = PW'(src_am) * PW'(SIN30_TAB[idx]);
      deg_in   = (in_range && (prod_b >= prod_a)) ? cand : src_deg;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         am_ff   <= src_am;
         bm_ff   <= src_bm;
         deg_ff  <= deg_in;
         side_ff <= src_side;
      end
   end

   assign am   = am_ff;
   assign bm   = bm_ff;
   assign deg  = deg_ff;
   assign side = side_ff;

endmodule

FILE: hdl/hacpm_mix.sv
// ----------------------------------------------------------------------------
// hacpm_mix
// Four-stage mixer: cyclic products, fraction drop, divide by ten, saturate.
// ----------------------------------------------------------------------------
module hacpm_mix
   import hacpm_pkg::*;
#(
   parameter int CMD_W = CMD_BITS_DEF
) (
   input  logic                     clock,
   input  logic [3:0]               adv,
   input  logic signed [15:0]       src_sin,
   input  logic signed [15:0]       src_cos,
   input  logic [CMD_W-1:0]         src_x,
   input  logic [CMD_W-1:0]         src_y,
   input  logic [CMD_W-1:0]         src_coll,
   input  logic [ANGLE_W-1:0]       src_angle,
   input  logic [BASE_W-1:0]        pulse_base,
   output logic [15:0]              pulse,
   output logic [ANGLE_W-1:0]       angle
);

   localparam int PROD_W = 17 + CMD_W;
   localparam int RW     = PROD_W + 3;
   localparam int VW     = RW - 16;
   localparam int K      = 1 << (VW - 1);
   localparam int OFS    = 10 * K;
   localparam int UW     = VW + 4;
   localparam int QW     = UW - 3;
   localparam int PW     = 18;
   localparam int RES_W  = ((UW > PW) ? UW : PW) + 2;

   // stage A: products and integer part
   logic signed [PROD_W-1:0] sx_ff, cy_ff;
   logic [PW-1:0]            p_a_ff;
   logic                     c0_ff;
   logic [ANGLE_W-1:0]       ang_a_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sx_ff    <= src_sin * signed'({1'b0, src_x});
         cy_ff    <= src_cos * signed'({1'b0, src_y});
         p_a_ff   <= PW'(pulse_base) + PW'(PULSE_OFFSET) + PW'(src_coll >> 1);
         c0_ff    <= src_coll[0];
         ang_a_ff <= src_angle;
      end
   end

   // stage B: fraction sum, floor by 65536, offset to positive
   logic signed [RW-1:0] r_sum;
   logic signed [VW-1:0] v_hi;
   logic [UW-1:0]        u_in, u_ff;
   logic [PW-1:0]        p_b_ff;
   logic [ANGLE_W-1:0]   ang_b_ff;

   always_comb begin
      r_sum = (RW'(sx_ff) <<< 1) + (RW'(cy_ff) <<< 1)
            + (c0_ff ? RW'(HALF_UNIT) : RW'(0));
      v_hi  = r_sum[RW-1:16];
      u_in  = UW'(UW'(v_hi) + UW'(OFS));
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         u_ff     <= u_in;
         p_b_ff   <= p_a_ff;
         ang_b_ff <= ang_a_ff;
      end
   end

   // stage C: floor divide by ten through the reciprocal
   logic [63:0]        q_prod;
   logic [QW-1:0]      q_ff;
   logic [PW-1:0]      p_c_ff;
   logic [ANGLE_W-1:0] ang_c_ff;

   assign q_prod = 64'(u_ff) * 64'(32'hCCCC_CCCD);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         q_ff     <= q_prod[35 +: QW];
         p_c_ff   <= p_b_ff;
         ang_c_ff <= ang_b_ff;
      end
   end

   // stage D: remove offset and saturate
   logic signed [RES_W-1:0] res;
   logic [15:0]             pulse_in, pulse_ff;
   logic [ANGLE_W-1:0]      ang_d_ff;

   always_comb begin
      res = signed'(RES_W'(p_c_ff)) + signed'(RES_W'(q_ff)) - signed'(RES_W'(K));
      if (res < 0)                         pulse_in = 16'd0;
      else if (res > signed'(RES_W'(65535))) pulse_in = 16'hFFFF;
      else                                 pulse_in = res[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         pulse_ff <= pulse_in;
         ang_d_ff <= ang_c_ff;
      end
   end

   assign pulse = pulse_ff;
   assign angle = ang_d_ff;

endmodule

FILE: hdl/hall_angle_cyclic_pulse_mixer.sv
// ----------------------------------------------------------------------------
// hall_angle_cyclic_pulse_mixer
// Pipeline: from req transaction to rsp_tvalid through the front end, seven
//   arctangent search steps, angle fix-up, trig lookup, four mixer stages.
// Throughput: one transaction per cycle; each stage holds only while the
//   stage after it is full and stalled, so bubbles are squeezed out.
// Reset: synchronous; clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module hall_angle_cyclic_pulse_mixer
   import hacpm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CMD_BITS    = CMD_BITS_DEF,
   localparam int REQ_W      = ((2 * SAMPLE_BITS + 3 * CMD_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hall_a_sample, hall_b_sample, cyclic_x_cmd, cyclic_y_cmd, collective_cmd
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pulse_compare[15:0], rotor_angle[24:16], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAG_W  = (SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W;
   localparam int DIFF_W = MAG_W + 1;
   localparam int FLG_W  = $bits(hacpm_flags_type);
   localparam int SIDE_W = FLG_W + 3 * CMD_BITS;
   localparam int N_ST   = 14;
   localparam int ST_ANG = SEARCH_STEPS + 1;
   localparam int ST_TRG = SEARCH_STEPS + 2;
   localparam int ST_MIX = SEARCH_STEPS + 3;

   // configuration registers
   logic [BASE_W-1:0]  base_ff;
   logic [MID_W-1:0]   mid_ff;
   logic [PHASE_W-1:0] phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= PULSE_BASE_RST;
         mid_ff   <= HALL_MID_RST;
         phase_ff <= PHASE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PULSE_BASE:    base_ff  <= csr_wdata[BASE_W-1:0];
            REG_HALL_MIDPOINT: mid_ff   <= csr_wdata[MID_W-1:0];
            REG_PHASE_OFFSET:  phase_ff <= csr_wdata[PHASE_W-1:0];
            default: ;
         endcase
      end
   end

   // valid chain and per-stage advance
   logic [N_ST-1:0] vld_ff;
   logic [N_ST-1:0] adv;

   always_comb begin
      adv[N_ST-1] = !vld_ff[N_ST-1] || rsp_tready;
      for (int i = N_ST - 2; i >= 0; i--) adv[i] = !vld_ff[i] || adv[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_tvalid;
         for (int i = 1; i < N_ST; i++) begin
            if (adv[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign req_tready = adv[0];

   // front end: unpack, remove midpoint, classify
   logic [SAMPLE_BITS-1:0]   samp_a, samp_b;
   logic [CMD_BITS-1:0]      cmd_x, cmd_y, cmd_c;
   logic signed [DIFF_W-1:0] dif_a, dif_b;
   hacpm_flags_type          flg_in;
   logic [MAG_W-1:0]         am_in, bm_in, am_ff, bm_ff;
   logic [SIDE_W-1:0]        side_ff;

   always_comb begin
      samp_a = req_tdata[0 +: SAMPLE_BITS];
      samp_b = req_tdata[SAMPLE_BITS +: SAMPLE_BITS];
      cmd_x  = req_tdata[2*SAMPLE_BITS +: CMD_BITS];
      cmd_y  = req_tdata[2*SAMPLE_BITS+CMD_BITS +: CMD_BITS];
      cmd_c  = req_tdata[2*SAMPLE_BITS+2*CMD_BITS +: CMD_BITS];
      dif_a  = signed'(DIFF_W'(samp_a)) - signed'(DIFF_W'(mid_ff));
      dif_b  = signed'(DIFF_W'(samp_b)) - signed'(DIFF_W'(mid_ff));
      am_in  = MAG_W'(dif_a[DIFF_W-1] ? -dif_a : dif_a);
      bm_in  = MAG_W'(dif_b[DIFF_W-1] ? -dif_b : dif_b);
      flg_in.a_neg = dif_a[DIFF_W-1];
      flg_in.b_neg = dif_b[DIFF_W-1];
      flg_in.eq    = (am_in == bm_in);
      // axis cases
      if (dif_b == '0) begin
         flg_in.special       = 1'b1;
         flg_in.special_angle = (dif_a > 0) ? DEG_0 : DEG_180;
      end else if (dif_a == '0) begin
         flg_in.special       = 1'b1;
         flg_in.special_angle = (dif_b > 0) ? DEG_90 : DEG_270;
      end else begin
         flg_in.special       = 1'b0;
         flg_in.special_angle = DEG_0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         am_ff   <= am_in;
         bm_ff   <= bm_in;
         side_ff <= {flg_in, cmd_c, cmd_y, cmd_x};
      end
   end

   // arctangent search, most significant degree bit first
   logic [MAG_W-1:0]  s_am   [0:SEARCH_STEPS];
   logic [MAG_W-1:0]  s_bm   [0:SEARCH_STEPS];
   logic [DEG_W-1:0]  s_deg  [0:SEARCH_STEPS];
   logic [SIDE_W-1:0] s_side [0:SEARCH_STEPS];

   assign s_am[0]   = am_ff;
   assign s_bm[0]   = bm_ff;
   assign s_deg[0]  = '0;
   assign s_side[0] = side_ff;

   for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_search
      hacpm_atan_stage #(
         .MAG_W    (MAG_W),
         .SIDE_W   (SIDE_W),
         .STEP_BIT (SEARCH_STEPS - 1 - g)
      ) u_step (
         .clock    (clock),
         .adv      (adv[g+1]),
         .src_am   (s_am[g]),
         .src_bm   (s_bm[g]),
         .src_deg  (s_deg[g]),
         .src_side (s_side[g]),
         .am       (s_am[g+1]),
         .bm       (s_bm[g+1]),
         .deg      (s_deg[g+1]),
         .side     (s_side[g+1])
      );
   end

   // angle fix-up by quadrant and phase wrap
   hacpm_flags_type           flg_s;
   logic [3*CMD_BITS-1:0]     cmd_s;
   logic [ANGLE_W-1:0]        fl, cl, ang_in, ang8_ff, ang9_ff;
   logic [ANGLE_W:0]          ph_sum;
   logic [ANGLE_W-1:0]        ph_in, ph_ff;
   logic [3*CMD_BITS-1:0]     cmd8_ff, cmd9_ff;

   always_comb begin
      flg_s = s_side[SEARCH_STEPS][SIDE_W-1 -: FLG_W];
      cmd_s = s_side[SEARCH_STEPS][3*CMD_BITS-1:0];
      fl    = ANGLE_W'(s_deg[SEARCH_STEPS]);
      cl    = fl + ANGLE_W'(!flg_s.eq);
      if (flg_s.special)     ang_in = flg_s.special_angle;
      else if (!flg_s.a_neg) ang_in = flg_s.b_neg ? DEG_360 - cl : fl;
      else                   ang_in = flg_s.b_neg ? DEG_180 + fl : DEG_180 - cl;
      ph_sum = (ANGLE_W + 1)'(ang_in) + (ANGLE_W + 1)'(phase_ff);
      if (ph_sum >= (ANGLE_W + 1)'(2 * DEG_360))
         ph_sum = ph_sum - (ANGLE_W + 1)'(2 * DEG_360);
      else if (ph_sum >= (ANGLE_W + 1)'(DEG_360))
         ph_sum = ph_sum - (ANGLE_W + 1)'(DEG_360);
      ph_in = ph_sum[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_ANG]) begin
         ang8_ff <= ang_in;
         ph_ff   <= ph_in;
         cmd8_ff <= cmd_s;
      end
   end

   // sine and cosine lookup
   logic [ANGLE_W-1:0] cph;
   logic signed [15:0] sin_ff, cos_ff;

   assign cph = (ph_ff >= DEG_270) ? ph_ff - DEG_270 : ph_ff + DEG_90;

   always_ff @(posedge clock) begin
      if (adv[ST_TRG]) begin
         sin_ff  <= sin_deg(ph_ff);
         cos_ff  <= sin_deg(cph);
         ang9_ff <= ang8_ff;
         cmd9_ff <= cmd8_ff;
      end
   end

   // mixer
   logic [15:0]        pulse;
   logic [ANGLE_W-1:0] angle;

   hacpm_mix #(
      .CMD_W (CMD_BITS)
   ) u_mix (
      .clock      (clock),
      .adv        (adv[ST_MIX +: 4]),
      .src_sin    (sin_ff),
      .src_cos    (cos_ff),
      .src_x      (cmd9_ff[0 +: CMD_BITS]),
      .src_y      (cmd9_ff[CMD_BITS +: CMD_BITS]),
      .src_coll   (cmd9_ff[2*CMD_BITS +: CMD_BITS]),
      .src_angle  (ang9_ff),
      .pulse_base (base_ff),
      .pulse      (pulse),
      .angle      (angle)
   );

   assign rsp_tvalid = vld_ff[N_ST-1];
   assign rsp_tdata  = {(RSP_DATA_W - 16 - ANGLE_W)'(0), angle, pulse};

endmodule

FILE: hdl/hacpm_checker.sv
// ----------------------------------------------------------------------------
// hacpm_checker
// Port-level checks of the hall angle cyclic pulse mixer.
// ----------------------------------------------------------------------------
`include "hall_angle_cyclic_pulse_mixer_defines.svh"

module hacpm_checker
   import hacpm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // nothing comes out straight after reset
   `HACPM_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")

   // an empty output stage means the whole pipeline can take a transaction
   `HACPM_ASSERT_RUN(a_ready_free, clock, reset, !rsp_tvalid |-> req_tready, "req_tready low")

   // rotor angle stays within one turn
   `HACPM_ASSERT_RUN(a_angle_rng, clock, reset, rsp_tvalid |-> rsp_tdata[24:16] < 9'd360, "angle")

   // pad bits stay clear
   `HACPM_ASSERT_RUN(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[31:25] == 7'd0, "pad")

   // stalled result holds
   `HACPM_ASSERT_RUN(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "hold")

endmodule

bind hall_angle_cyclic_pulse_mixer hacpm_checker u_hacpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
